/* src/pdm_pkg.sv */
package pdm_pkg;

  localparam int GainFracBitsDef = 8;
  localparam int MsPerSec        = 1000;
  localparam int SettleBand      = 16;

  localparam int DivWidth  = 49;
  localparam int DivorWidth = 10;

  localparam int         RecipShift = 34;
  localparam logic [24:0] RecipMul  =
    25'(((64'd1 << RecipShift) + 64'(MsPerSec) - 64'd1) / 64'(MsPerSec));

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_STRAIGHT = 3'd1;
  localparam logic [2:0] CMD_TURN     = 3'd2;
  localparam logic [2:0] CMD_WAIT     = 3'd3;
  localparam logic [2:0] CMD_STOP     = 3'd4;

  localparam logic [2:0] CFG_GAIN_P      = 3'd0;
  localparam logic [2:0] CFG_GAIN_I      = 3'd1;
  localparam logic [2:0] CFG_GAIN_D      = 3'd2;
  localparam logic [2:0] CFG_MOTOR_LIMIT = 3'd3;
  localparam logic [2:0] CFG_ACCEL_LIMIT = 3'd4;
  localparam logic [2:0] CFG_INT_LIMIT   = 3'd5;
  localparam logic [2:0] CFG_SETTLE_TIME = 3'd6;
  localparam logic [2:0] CFG_SETTLE_SPD  = 3'd7;

  typedef enum logic [1:0] {
    MODE_STOP     = 2'd0,
    MODE_STRAIGHT = 2'd1,
    MODE_TURN     = 2'd2,
    MODE_WAIT     = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_INT_MUL, ST_INT_CLAMP, ST_P_MUL, ST_I_MUL, ST_D_MUL,
    ST_D_START, ST_D_WAIT, ST_SHAPE, ST_S_MUL, ST_S_START, ST_S_WAIT, ST_OUT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DECODE, OP_INT_MUL, OP_INT_CLAMP, OP_P_MUL, OP_I_MUL,
    OP_D_MUL, OP_D_START, OP_D_ACC, OP_SHAPE, OP_S_MUL, OP_S_START, OP_SLEW,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic drive;
    logic dt_zero;
    logic div_done;
  } dp_status_t;

endpackage

/* src/pid_drive_move_controller.sv */
// Two-wheel drive move controller. Start commands arm a straight, turn or wait
// move; each tick item of a straight or turn move runs a clamped-integrator PID
// on left wheel travel, limits speed to the move and motor ceilings and to an
// acceleration slew, and returns wheel speeds (right negated for a turn) with
// the mode after the item. One result item per input item. A drive tick makes
// one pass through the bit-serial divider for the derivative term over
// elapsed time (49 iterations); the slew step over 1000 ms uses a reciprocal
// multiply. With zero elapsed time a drive tick skips the PID and the divider,
// and every other item goes from decode straight to output. A stalled result
// holds the next result back until the stall clears. Input items are taken one
// at a time; the next may enter while a result waits.
module pid_drive_move_controller #(
  parameter int GainFracBits = pdm_pkg::GainFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] position_i,
  input  logic signed [31:0] target_i,
  input  logic [14:0]        move_speed_limit_i,
  input  logic [7:0]         elapsed_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] left_speed_o,
  output logic signed [15:0] right_speed_o,
  output logic [1:0]         move_mode_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i
);
  import pdm_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  pdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (dp_cmd),
    .status_i   (dp_status)
  );

  pdm_datapath #(
    .GainFracBits(GainFracBits)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .status_o          (dp_status),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .command_i         (command_i),
    .position_i        (position_i),
    .target_i          (target_i),
    .move_speed_limit_i(move_speed_limit_i),
    .elapsed_ms_i      (elapsed_ms_i),
    .left_speed_o      (left_speed_o),
    .right_speed_o     (right_speed_o),
    .move_mode_o       (move_mode_o)
  );

endmodule

/* src/pdm_div.sv */
module pdm_div #(
  parameter int DW = 49,
  parameter int VW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [DW-1:0] quotient_o,
  output logic          done_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd_q, dvd_d;
  logic [VW-1:0] rem_q, rem_d, dsr_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [VW:0]   rem_sh;
  logic          ge;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DW-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? VW'(rem_sh - {1'b0, dsr_q}) : rem_sh[VW-1:0];
      dvd_d = {dvd_q[DW-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign quotient_o = dvd_q;
  assign done_o     = !busy_q;

endmodule

/* src/pdm_ctrl.sv */
module pdm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pdm_pkg::dp_cmd_t    cmd_o,
  input  pdm_pkg::dp_status_t status_i
);
  import pdm_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (!status_i.drive) state_d = ST_OUT;
        else if (status_i.dt_zero) state_d = ST_SHAPE;
        else state_d = ST_INT_MUL;
      end
      ST_INT_MUL:   state_d = ST_INT_CLAMP;
      ST_INT_CLAMP: state_d = ST_P_MUL;
      ST_P_MUL:     state_d = ST_I_MUL;
      ST_I_MUL:     state_d = ST_D_MUL;
      ST_D_MUL:     state_d = ST_D_START;
      ST_D_START:   state_d = ST_D_WAIT;
      ST_D_WAIT: begin
        if (status_i.div_done) state_d = ST_SHAPE;
      end
      ST_SHAPE:     state_d = ST_S_MUL;
      ST_S_MUL:     state_d = ST_S_START;
      ST_S_START:   state_d = ST_S_WAIT;
      ST_S_WAIT:    state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op    = OP_NONE;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE:      if (in_valid_i) cmd_o.op = OP_LOAD;
      ST_DECODE:    cmd_o.op = OP_DECODE;
      ST_INT_MUL:   cmd_o.op = OP_INT_MUL;
      ST_INT_CLAMP: cmd_o.op = OP_INT_CLAMP;
      ST_P_MUL:     cmd_o.op = OP_P_MUL;
      ST_I_MUL:     cmd_o.op = OP_I_MUL;
      ST_D_MUL:     cmd_o.op = OP_D_MUL;
      ST_D_START:   cmd_o.op = OP_D_START;
      ST_D_WAIT:    if (status_i.div_done) cmd_o.op = OP_D_ACC;
      ST_SHAPE:     cmd_o.op = OP_SHAPE;
      ST_S_MUL:     cmd_o.op = OP_S_MUL;
      ST_S_START:   cmd_o.op = OP_S_START;
      ST_S_WAIT:    cmd_o.op = OP_SLEW;
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = OP_EMIT;
          out_valid_d = 1'b1;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

/* src/pdm_datapath.sv */
module pdm_datapath #(
  parameter int GainFracBits = pdm_pkg::GainFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pdm_pkg::dp_cmd_t    cmd_i,
  output pdm_pkg::dp_status_t status_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [30:0]         cfg_data_i,
  input  logic [2:0]          command_i,
  input  logic signed [31:0]  position_i,
  input  logic signed [31:0]  target_i,
  input  logic [14:0]         move_speed_limit_i,
  input  logic [7:0]          elapsed_ms_i,
  output logic signed [15:0]  left_speed_o,
  output logic signed [15:0]  right_speed_o,
  output logic [1:0]          move_mode_o
);
  import pdm_pkg::*;

  localparam int ShiftAmt = GainFracBits - 4;

  logic [15:0] gain_p_q, gain_i_q, gain_d_q, accel_q, settle_time_q;
  logic [14:0] motor_lim_q, settle_spd_q;
  logic [30:0] int_lim_q;

  logic [2:0]         cmd_q;
  logic signed [31:0] pos_q, tgt_q;
  logic [14:0]        msl_q;
  logic [7:0]         dt_q;

  mode_e              mode_q;
  logic signed [31:0] start_q, tdist_q, integ_q, perr_q, wdur_q;
  logic [14:0]        cap_q;
  logic signed [15:0] pspd_q;
  logic [16:0]        stmr_q;
  logic               armed_q;
  logic [31:0]        wel_q;

  logic signed [33:0] diff_q;
  logic signed [31:0] err_q;
  logic signed [32:0] dlt_q;
  logic signed [50:0] prod_q;
  logic signed [51:0] acc_q;
  logic signed [16:0] spd_q;
  logic [14:0]        step_q;
  logic signed [15:0] res_l_q, res_r_q;
  logic signed [15:0] out_l_q, out_r_q;
  logic [1:0]         out_m_q;

  logic signed [33:0] travel, diff;
  logic signed [31:0] err_sat;
  logic signed [32:0] dlt;
  logic               drive;
  logic [32:0]        wsum;
  logic [31:0]        wnext;

  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [50:0] prod_w;

  logic signed [51:0] isum, ilim;
  logic signed [31:0] inew;

  logic signed [51:0] shifted, capv, motv, c1, c2;
  logic [32:0]        dlt_abs;

  logic [DivWidth-1:0]   div_dvd, div_quo;
  logic [DivorWidth-1:0] div_dsr;
  logic                  div_start, div_done;

  logic [48:0]        sprod;

  logic signed [17:0] step, spd18, prev18, snew, sabs, pabs_lim, pabs;
  logic               in_band;
  logic [17:0]        tsum;
  logic [16:0]        tnext;
  logic               anext;

  always_comb begin
    travel  = {{2{pos_q[31]}}, pos_q} - {{2{start_q[31]}}, start_q};
    diff    = {{2{tdist_q[31]}}, tdist_q} - travel;
    if (diff > 34'sh07FFFFFFF) err_sat = 32'sh7FFFFFFF;
    else if (diff < -34'sh080000000) err_sat = 32'sh80000000;
    else err_sat = diff[31:0];
    dlt     = {err_sat[31], err_sat} - {perr_q[31], perr_q};
    drive   = (cmd_q == CMD_TICK) && (mode_q == MODE_STRAIGHT || mode_q == MODE_TURN);
    wsum    = {1'b0, wel_q} + {25'd0, dt_q};
    wnext   = wsum[32] ? 32'hFFFFFFFF : wsum[31:0];
  end

  always_comb begin
    dlt_abs = dlt_q[32] ? 33'(-dlt_q) : 33'(dlt_q);
    mul_a   = '0;
    mul_b   = '0;
    case (cmd_i.op)
      OP_INT_MUL: begin
        mul_a = {{2{err_q[31]}}, err_q};
        mul_b = {9'd0, dt_q};
      end
      OP_P_MUL: begin
        mul_a = {{2{err_q[31]}}, err_q};
        mul_b = {1'b0, gain_p_q};
      end
      OP_I_MUL: begin
        mul_a = {{2{integ_q[31]}}, integ_q};
        mul_b = {1'b0, gain_i_q};
      end
      OP_D_MUL: begin
        mul_a = {1'b0, dlt_abs};
        mul_b = {1'b0, gain_d_q};
      end
      OP_S_MUL: begin
        mul_a = {18'd0, accel_q};
        mul_b = {9'd0, dt_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_w = mul_a * mul_b;
  end

  always_comb begin
    isum = {{20{integ_q[31]}}, integ_q} + {prod_q[50], prod_q};
    ilim = {21'd0, int_lim_q};
    if (isum > ilim) inew = ilim[31:0];
    else if (isum < -ilim) inew = 32'(-ilim);
    else inew = isum[31:0];
  end

  always_comb begin
    shifted = acc_q >>> ShiftAmt;
    capv    = {37'd0, cap_q};
    motv    = {37'd0, motor_lim_q};
    if (shifted > capv) c1 = capv;
    else if (shifted < -capv) c1 = -capv;
    else c1 = shifted;
    if (c1 > motv) c2 = motv;
    else if (c1 < -motv) c2 = -motv;
    else c2 = c1;
  end

  always_comb begin
    div_start = cmd_i.op == OP_D_START;
    div_dvd   = prod_q[DivWidth-1:0];
    div_dsr   = {2'd0, dt_q};
    sprod     = prod_q[23:0] * RecipMul;
  end

  pdm_div #(
    .DW(DivWidth),
    .VW(DivorWidth)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dsr),
    .quotient_o(div_quo),
    .done_o    (div_done)
  );

  always_comb begin
    step     = {3'd0, step_q};
    spd18    = {spd_q[16], spd_q};
    prev18   = {{2{pspd_q[15]}}, pspd_q};
    pabs     = prev18[17] ? -prev18 : prev18;
    sabs     = spd18[17] ? -spd18 : spd18;
    pabs_lim = pabs + step;
    if (sabs > pabs_lim) snew = (spd18 > 0) ? prev18 + step : prev18 - step;
    else snew = spd18;
    in_band  = (diff_q > -34'(SettleBand)) && (diff_q < 34'(SettleBand)) &&
               ((snew[17] ? -snew : snew) < {3'd0, settle_spd_q});
    tsum     = {1'b0, stmr_q} + {10'd0, dt_q};
    if (!in_band) begin
      anext = 1'b0;
      tnext = '0;
    end else if (!armed_q) begin
      anext = 1'b1;
      tnext = '0;
    end else begin
      anext = 1'b1;
      tnext = tsum[17] ? 17'h1FFFF : tsum[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q      <= 16'd3840;
      gain_i_q      <= 16'd38;
      gain_d_q      <= 16'd0;
      motor_lim_q   <= 15'd1280;
      accel_q       <= 16'd512;
      int_lim_q     <= 31'd1600;
      settle_time_q <= 16'd1000;
      settle_spd_q  <= 15'd38;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GAIN_P:      gain_p_q      <= cfg_data_i[15:0];
        CFG_GAIN_I:      gain_i_q      <= cfg_data_i[15:0];
        CFG_GAIN_D:      gain_d_q      <= cfg_data_i[15:0];
        CFG_MOTOR_LIMIT: motor_lim_q   <= cfg_data_i[14:0];
        CFG_ACCEL_LIMIT: accel_q       <= cfg_data_i[15:0];
        CFG_INT_LIMIT:   int_lim_q     <= cfg_data_i;
        CFG_SETTLE_TIME: settle_time_q <= cfg_data_i[15:0];
        CFG_SETTLE_SPD:  settle_spd_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_STOP;
      start_q <= '0;
      tdist_q <= '0;
      cap_q   <= '0;
      integ_q <= '0;
      perr_q  <= '0;
      pspd_q  <= '0;
      stmr_q  <= '0;
      armed_q <= 1'b0;
      wel_q   <= '0;
      wdur_q  <= '0;
    end else begin
      case (cmd_i.op)
        OP_DECODE: begin
          case (cmd_q)
            CMD_STRAIGHT, CMD_TURN: begin
              mode_q  <= (cmd_q == CMD_STRAIGHT) ? MODE_STRAIGHT : MODE_TURN;
              tdist_q <= tgt_q;
              start_q <= pos_q;
              cap_q   <= msl_q;
              wel_q   <= '0;
              stmr_q  <= '0;
              armed_q <= 1'b0;
            end
            CMD_WAIT: begin
              mode_q <= MODE_WAIT;
              wdur_q <= tgt_q;
              wel_q  <= '0;
            end
            CMD_STOP: mode_q <= MODE_STOP;
            CMD_TICK: begin
              if (mode_q == MODE_WAIT) begin
                wel_q <= wnext;
                if ($signed({1'b0, wnext}) > $signed({wdur_q[31], wdur_q})) begin
                  mode_q <= MODE_STOP;
                end
              end
            end
            default: ;
          endcase
        end
        OP_INT_CLAMP: begin
          integ_q <= inew;
          perr_q  <= err_q;
        end
        OP_SLEW: begin
          pspd_q  <= snew[15:0];
          stmr_q  <= tnext;
          armed_q <= anext;
          if (anext && (tnext > {1'b0, settle_time_q})) begin
            mode_q <= MODE_STOP;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cmd_q <= command_i;
        pos_q <= position_i;
        tgt_q <= target_i;
        msl_q <= move_speed_limit_i;
        dt_q  <= elapsed_ms_i;
      end
      OP_DECODE: begin
        diff_q  <= diff;
        err_q   <= err_sat;
        dlt_q   <= dlt;
        acc_q   <= '0;
        res_l_q <= '0;
        res_r_q <= '0;
      end
      OP_INT_MUL, OP_P_MUL, OP_S_MUL: prod_q <= prod_w;
      OP_I_MUL: begin
        acc_q  <= {prod_q[50], prod_q};
        prod_q <= prod_w;
      end
      OP_D_MUL: begin
        acc_q  <= acc_q + {prod_q[50], prod_q};
        prod_q <= prod_w;
      end
      OP_D_ACC: begin
        if (dlt_q[32]) acc_q <= acc_q - {3'd0, div_quo};
        else acc_q <= acc_q + {3'd0, div_quo};
      end
      OP_SHAPE: spd_q <= c2[16:0];
      OP_S_START: step_q <= sprod[48:RecipShift];
      OP_SLEW: begin
        res_l_q <= snew[15:0];
        res_r_q <= (mode_q == MODE_TURN) ? 16'(-snew) : snew[15:0];
      end
      OP_EMIT: begin
        out_l_q <= res_l_q;
        out_r_q <= res_r_q;
        out_m_q <= mode_q;
      end
      default: ;
    endcase
  end

  assign status_o.drive    = drive;
  assign status_o.dt_zero  = dt_q == 8'd0;
  assign status_o.div_done = div_done;

  assign left_speed_o  = out_l_q;
  assign right_speed_o = out_r_q;
  assign move_mode_o   = out_m_q;

endmodule

/* src/pdm_checker.sv */
module pdm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic signed [15:0] left_speed_o,
  input logic signed [15:0] right_speed_o,
  input logic [1:0]        move_mode_o
);
  import pdm_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_speed_o) &&
      $stable(right_speed_o) && $stable(move_mode_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && move_mode_o == MODE_WAIT |-> left_speed_o == 16'sd0 &&
      right_speed_o == 16'sd0)
    else $error("nonzero speed in wait mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && move_mode_o == MODE_STRAIGHT |-> left_speed_o == right_speed_o)
    else $error("wheels differ on straight move");

endmodule

bind pid_drive_move_controller pdm_checker u_pdm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .left_speed_o (left_speed_o),
  .right_speed_o(right_speed_o),
  .move_mode_o  (move_mode_o)
);

/* tb/tb_pid_drive_move_controller.sv */
module tb_pid_drive_move_controller;
  import pdm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GainFrac = GainFracBitsDef;
  localparam longint CycleLimit = 3000000;
  localparam int DrainCycles = 150;

  typedef struct {
    logic [2:0]         command;
    logic signed [31:0] position;
    logic signed [31:0] target;
    logic [14:0]        speed_limit;
    logic [7:0]         elapsed;
  } drive_item_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [1:0]         mode;
  } wheel_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] command_i = CMD_STOP;
  logic signed [31:0] position_i = '0;
  logic signed [31:0] target_i = '0;
  logic [14:0] move_speed_limit_i = '0;
  logic [7:0] elapsed_ms_i = 8'd1;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] left_speed_o;
  logic signed [15:0] right_speed_o;
  logic [1:0] move_mode_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = CFG_GAIN_P;
  logic [30:0] cfg_data_i = '0;

  pid_drive_move_controller DUT (.*);

  always #10 clk_i = ~clk_i;

  drive_item_t   pending_items[$];
  wheel_result_t expected_speeds[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit driving = 1'b0;
  bit took_item = 1'b0;
  int fail_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int move_ends = 0;
  int reg_writes = 0;
  longint cycle_count = 0;

  longint gain_p, gain_i, gain_d, motor_limit, accel_limit, int_limit;
  longint settle_time, settle_speed;
  mode_e  cur_mode;
  longint start_pos, tgt_dist, speed_cap, integ, prev_err, prev_speed;
  longint settle_tmr, wait_el, wait_dur;
  bit     settle_armed;

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint drive_speed(logic signed [31:0] pos, logic [7:0] dt);
    longint travel, diff, err, deriv, raw, spd, step;
    travel = longint'(pos) - start_pos;
    diff = tgt_dist - travel;
    err = diff;
    if (err > 64'sd2147483647) err = 64'sd2147483647;
    if (err < -64'sd2147483648) err = -64'sd2147483648;
    if (dt == 0) begin
      spd = 0;
    end else begin
      integ = clamp_sym(integ + err * longint'(dt), int_limit);
      deriv = (gain_d * (err - prev_err)) / longint'(dt);
      raw = gain_p * err + gain_i * integ + deriv;
      prev_err = err;
      spd = raw >>> (GainFrac - 4);
    end
    spd = clamp_sym(spd, speed_cap);
    spd = clamp_sym(spd, motor_limit);
    step = (accel_limit * longint'(dt)) / 1000;
    if (abs_l(spd) > abs_l(prev_speed) + step)
      spd = spd > 0 ? prev_speed + step : prev_speed - step;
    prev_speed = spd;
    if (abs_l(diff) < 16 && abs_l(spd) < settle_speed) begin
      if (!settle_armed) begin
        settle_armed = 1'b1;
        settle_tmr = 0;
      end else begin
        settle_tmr += dt;
        if (settle_tmr > 17'h1FFFF) settle_tmr = 17'h1FFFF;
      end
    end else begin
      settle_armed = 1'b0;
      settle_tmr = 0;
    end
    if (settle_armed && settle_tmr > settle_time) cur_mode = MODE_STOP;
    return spd;
  endfunction

  function automatic wheel_result_t predict_speeds(drive_item_t it);
    wheel_result_t r;
    longint lft, rgt;
    mode_e old_mode;
    lft = 0;
    rgt = 0;
    old_mode = cur_mode;
    case (it.command)
      CMD_STRAIGHT, CMD_TURN: begin
        cur_mode = it.command == CMD_STRAIGHT ? MODE_STRAIGHT : MODE_TURN;
        tgt_dist = longint'(it.target);
        start_pos = longint'(it.position);
        speed_cap = it.speed_limit;
        wait_el = 0;
        settle_tmr = 0;
        settle_armed = 1'b0;
      end
      CMD_WAIT: begin
        cur_mode = MODE_WAIT;
        wait_dur = longint'(it.target);
        wait_el = 0;
      end
      CMD_STOP: cur_mode = MODE_STOP;
      CMD_TICK: begin
        if (cur_mode == MODE_STRAIGHT || cur_mode == MODE_TURN) begin
          lft = drive_speed(it.position, it.elapsed);
          rgt = old_mode == MODE_TURN ? -lft : lft;
        end else if (cur_mode == MODE_WAIT) begin
          wait_el += it.elapsed;
          if (wait_el > 64'hFFFFFFFF) wait_el = 64'hFFFFFFFF;
          if (wait_el > wait_dur) cur_mode = MODE_STOP;
        end
        if (old_mode != MODE_STOP && cur_mode == MODE_STOP) move_ends++;
      end
      default: ;
    endcase
    r.left = lft[15:0];
    r.right = rgt[15:0];
    r.mode = cur_mode;
    return r;
  endfunction

  always @(posedge clk_i) begin
    took_item = in_valid_i && !in_stall_o;
    if (took_item) begin
      drive_item_t it;
      it.command = command_i;
      it.position = position_i;
      it.target = target_i;
      it.speed_limit = move_speed_limit_i;
      it.elapsed = elapsed_ms_i;
      expected_speeds.push_back(predict_speeds(it));
      items_sent++;
    end
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_speeds.size() == 0) begin
        $error("result with nothing expected: left %0d right %0d mode %0d",
               left_speed_o, right_speed_o, move_mode_o);
        fail_count++;
      end else begin
        wheel_result_t e;
        e = expected_speeds.pop_front();
        if (left_speed_o !== e.left) begin
          $error("left_speed expected %0d got %0d", e.left, left_speed_o);
          fail_count++;
        end
        if (right_speed_o !== e.right) begin
          $error("right_speed expected %0d got %0d", e.right, right_speed_o);
          fail_count++;
        end
        if (move_mode_o !== e.mode) begin
          $error("move_mode expected %0d got %0d", e.mode, move_mode_o);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (driving && (!in_valid_i || took_item)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_item_t it;
        it = pending_items.pop_front();
        command_i <= it.command;
        position_i <= it.position;
        target_i <= it.target;
        move_speed_limit_i <= it.speed_limit;
        elapsed_ms_i <= it.elapsed;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= $urandom_range(99) < recv_stall_pct;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("pid_drive_move_controller regression: fail");
      $finish;
    end
  end

  task automatic add_item(logic [2:0] cmd, logic [31:0] pos, logic [31:0] tgt,
                          logic [14:0] lim, logic [7:0] dt);
    drive_item_t it;
    it.command = cmd;
    it.position = pos;
    it.target = tgt;
    it.speed_limit = lim;
    it.elapsed = dt;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(logic [2:0] idx, longint value);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= value[30:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_GAIN_P:      gain_p = value & 16'hFFFF;
      CFG_GAIN_I:      gain_i = value & 16'hFFFF;
      CFG_GAIN_D:      gain_d = value & 16'hFFFF;
      CFG_MOTOR_LIMIT: motor_limit = value & 15'h7FFF;
      CFG_ACCEL_LIMIT: accel_limit = value & 16'hFFFF;
      CFG_INT_LIMIT:   int_limit = value & 31'h7FFFFFFF;
      CFG_SETTLE_TIME: settle_time = value & 16'hFFFF;
      default:         settle_speed = value & 15'h7FFF;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_speeds.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_move();
    logic [31:0] pos0, tgt;
    logic [14:0] cap;
    int n_app, n_hold;
    pos0 = $urandom;
    tgt = $urandom_range(1) ? $urandom_range(4000) : -$urandom_range(4000);
    if ($urandom_range(9) == 0) tgt = $urandom;
    cap = $urandom_range(3) == 0 ? 15'($urandom) : 15'($urandom_range(40));
    n_app = $urandom_range(8);
    n_hold = $urandom_range(3, 15);
    add_item($urandom_range(1) ? CMD_STRAIGHT : CMD_TURN, pos0, tgt, cap, 8'($urandom));
    for (int k = 1; k <= n_app; k++)
      add_item(CMD_TICK, 32'(pos0 + (longint'($signed(tgt)) * k) / (n_app + 1)), $urandom,
               15'($urandom), 8'($urandom_range(1, 255)));
    for (int k = 0; k < n_hold; k++)
      add_item(CMD_TICK, pos0 + tgt + $urandom_range(30) - 15, $urandom, 15'($urandom),
               $urandom_range(3) == 0 ? 8'($urandom_range(1, 255)) :
                                        8'($urandom_range(1, 20)));
  endtask

  task automatic queue_wait();
    int n;
    n = $urandom_range(1, 8);
    add_item(CMD_WAIT, $urandom, $urandom_range(3) == 0 ? $urandom : $urandom_range(300),
             15'($urandom), 8'($urandom));
    for (int k = 0; k < n; k++)
      add_item(CMD_TICK, $urandom, $urandom, 15'($urandom), 8'($urandom_range(1, 255)));
  endtask

  task automatic queue_noise();
    add_item(3'($urandom_range(7)), $urandom, $urandom, 15'($urandom),
             8'($urandom_range(1, 255)));
  endtask

  initial begin
    longint cfg_vals[8];
    gain_p = 3840; gain_i = 38; gain_d = 0; motor_limit = 1280; accel_limit = 512;
    int_limit = 1600; settle_time = 1000; settle_speed = 38;
    cur_mode = MODE_STOP;
    start_pos = 0; tgt_dist = 0; speed_cap = 0; integ = 0; prev_err = 0;
    prev_speed = 0; settle_tmr = 0; settle_armed = 1'b0; wait_el = 0; wait_dur = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    driving = 1'b1;

    add_item(CMD_STOP, 0, 0, 0, 1);
    add_item(CMD_TICK, 0, 0, 0, 1);
    add_item(CMD_STRAIGHT, 32'h80000000, 32'h7FFFFFFF, 15'h7FFF, 0);
    add_item(CMD_TICK, 32'h7FFFFFFF, 0, 0, 255);
    add_item(CMD_TICK, 32'h7FFFFFFF, 0, 0, 0);
    add_item(CMD_TICK, 32'h80000000, 0, 0, 1);
    add_item(CMD_TURN, 32'h7FFFFFFF, 32'h80000000, 15'h7FFF, 255);
    add_item(CMD_TICK, 32'h80000000, 32'hFFFFFFFF, 15'h7FFF, 255);
    add_item(CMD_TICK, 32'h80000000, 0, 0, 0);
    add_item(CMD_STRAIGHT, 100, 0, 20, 1);
    add_item(CMD_TICK, 100, 0, 0, 10);
    add_item(CMD_TICK, 100, 0, 0, 255);
    add_item(CMD_TICK, 100, 0, 0, 255);
    add_item(CMD_TICK, 105, 0, 0, 255);
    add_item(CMD_TICK, 95, 0, 0, 255);
    add_item(CMD_WAIT, 0, 32'hFFFFFFFF, 0, 1);
    add_item(CMD_TICK, 0, 0, 0, 1);
    add_item(CMD_WAIT, 0, 32'h7FFFFFFF, 0, 1);
    add_item(CMD_TICK, 0, 0, 0, 255);
    add_item(3'd5, 0, 0, 0, 1);
    add_item(3'd6, 0, 0, 0, 1);
    add_item(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 15'h7FFF, 8'hFF);
    add_item(CMD_STOP, 0, 0, 0, 1);
    wait_quiet();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 22; recv_stall_pct = 45; end
        1: begin send_idle_pct = 45; recv_stall_pct = 22; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      case (ph)
        0: cfg_vals = '{3840, 38, 0, 1280, 512, 1600, 1000, 38};
        1: cfg_vals = '{3840, 38, 200, 1280, 512, 1600, 20, 38};
        2: cfg_vals = '{65535, 65535, 65535, 32767, 65535, 2147483647, 65535, 32767};
        3: cfg_vals = '{0, 0, 0, 0, 0, 0, 0, 0};
        4: cfg_vals = '{$urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                        $urandom_range(32767), $urandom_range(65535), $urandom,
                        $urandom_range(65535), $urandom_range(32767)};
        default: cfg_vals = '{$urandom_range(4000), $urandom_range(200),
                               $urandom_range(500), $urandom_range(2000),
                               $urandom_range(2000), $urandom_range(5000),
                               $urandom_range(30), $urandom_range(20, 100)};
      endcase
      if (ph > 0)
        for (int r = 0; r < 8; r++) write_reg(3'(r), cfg_vals[r]);
      for (int n = 0; n < 235; ) begin
        int pick, before_sz;
        pick = $urandom_range(9);
        before_sz = pending_items.size();
        if (pick < 6) queue_move();
        else if (pick < 8) queue_wait();
        else queue_noise();
        n += pending_items.size() - before_sz;
      end
      wait_quiet();
    end

    $display("%0d items, %0d results, %0d move completions, %0d register writes",
             items_sent, results_seen, move_ends, reg_writes);
    $display("covered reset, nominal, extreme-max, all-zero and random register sets");
    if (fail_count == 0) begin
      $display("pid_drive_move_controller regression: pass");
    end else begin
      $display("pid_drive_move_controller regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
src/pdm_pkg.sv
src/pdm_div.sv
src/pdm_ctrl.sv
src/pdm_datapath.sv
src/pid_drive_move_controller.sv
src/pdm_checker.sv
tb/tb_pid_drive_move_controller.sv
